// ===== hw/rtl/quaternion_to_euler_angles_defines.svh =====
// assertion macros for the quaternion to euler angles block
// depends on nothing, taken in by the top level only
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qte check failed");

// next-cycle implication, disabled in reset
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte check failed");

`endif

// ===== hw/rtl/qte_pkg.sv =====
// shared types and constants for the quaternion to euler angles block
// angle format, arctangent table; depends on nothing
package qte_pkg;

  localparam int AngW    = 28;
  localparam int AngFrac = 24;

  typedef logic signed [AngW-1:0] ang_t;

  localparam ang_t AngHalfPi = 28'sd26353589;
  localparam ang_t OutPi     = 28'sd25736;
  localparam ang_t OutHalfPi = 28'sd12868;

  localparam ang_t AtanLow [8] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069
  };

  // atan(2^-i) with 24 fraction bits, rounded to nearest
  function automatic ang_t atan_entry(input int unsigned i);
    logic [AngW-1:0] unit;
    unit = {{(AngW-1){1'b0}}, 1'b1};
    if (i < 8) begin
      return AtanLow[i[2:0]];
    end else if (i <= AngFrac) begin
      return ang_t'(unit << (AngFrac - i));
    end
    return '0;
  endfunction

endpackage

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// quaternion (q1.14) to roll and yaw (q2.13 radians) and pitch (q1.13 radians), fully pipelined
// throughput one word per cycle while the output side does not stall the pipeline; a word
// is registered through the products, the sums, the sqrt digit stages, the cordic
// pre-rotation, the cordic iteration stages and the output register, in that order
// reset clears only the stage valid bits and the output valid; no other state
// depends on qte_pkg, qte_cordic and quaternion_to_euler_angles_defines.svh
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES  = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);

  // width of the product sums: room for 2^(2F) plus twice a sum of two products
  localparam int SumTop = (2 * QUAT_FRAC_BITS > 32) ? 2 * QUAT_FRAC_BITS : 32;
  localparam int AW     = SumTop + 2;
  // sqrt digit steps, one pipeline stage each
  localparam int NSQ    = AW / 2;
  // valid bits: products, sums, sqrt steps, cordic pre-rotation, cordic iterations
  localparam int PD     = 3 + NSQ + CORDIC_STAGES;

  localparam logic signed [AW-1:0] One =
    {{(AW-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);

  // pipeline control: everything moves unless the last stage holds a word
  // and the output register is full and not being drained
  logic          en;
  logic [PD-1:0] pv_q;
  logic          out_valid_q;

  assign en         = !pv_q[PD-1] || !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[PD-2:0], in_valid_i};
    end
  end

  // stage 1: the nine products, 16x16 signed each
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q;
  logic signed [31:0] p_wy_q, p_xz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= quat_w_i * quat_x_i;
      p_yz_q <= quat_y_i * quat_z_i;
      p_xx_q <= quat_x_i * quat_x_i;
      p_yy_q <= quat_y_i * quat_y_i;
      p_wz_q <= quat_w_i * quat_z_i;
      p_xy_q <= quat_x_i * quat_y_i;
      p_zz_q <= quat_z_i * quat_z_i;
      p_wy_q <= quat_w_i * quat_y_i;
      p_xz_q <= quat_x_i * quat_z_i;
    end
  end

  // stage 2: atan2 vectors for roll and yaw, clamped sqrt arguments for pitch
  logic signed [AW-1:0] roll_y_q, roll_x_q, yaw_y_q, yaw_x_q;
  logic signed [AW-1:0] sq_a_q, sq_b_q;
  logic signed [AW-1:0] t2, a_d, b_d;

  assign t2  = (AW'(p_wy_q) - AW'(p_xz_q)) <<< 1;
  assign a_d = One + t2;
  assign b_d = One - t2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_y_q <= (AW'(p_wx_q) + AW'(p_yz_q)) <<< 1;
      roll_x_q <= One - ((AW'(p_xx_q) + AW'(p_yy_q)) <<< 1);
      yaw_y_q  <= (AW'(p_wz_q) + AW'(p_xy_q)) <<< 1;
      yaw_x_q  <= One - ((AW'(p_yy_q) + AW'(p_zz_q)) <<< 1);
      sq_a_q   <= a_d[AW-1] ? '0 : a_d;
      sq_b_q   <= b_d[AW-1] ? '0 : b_d;
    end
  end

  // sqrt: restoring digit recurrence, one digit per stage, for both arguments;
  // roll and yaw vectors ride along in a matching delay line
  logic [AW-1:0]        ra_q [NSQ];
  logic [AW-1:0]        ta_q [NSQ];
  logic [AW-1:0]        rb_q [NSQ];
  logic [AW-1:0]        tb_q [NSQ];
  logic signed [AW-1:0] d_ry_q[NSQ];
  logic signed [AW-1:0] d_rx_q[NSQ];
  logic signed [AW-1:0] d_yy_q[NSQ];
  logic signed [AW-1:0] d_yx_q[NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [AW-1:0] Bit = {{(AW-1){1'b0}}, 1'b1} << (AW - 2 - 2 * k);
    logic [AW-1:0]        rem_a, root_a, rem_b, root_b;
    logic signed [AW-1:0] ry, rx, yy, yx;
    logic [AW:0]          trial_a, trial_b;

    if (k == 0) begin : g_first
      assign rem_a  = sq_a_q;
      assign root_a = '0;
      assign rem_b  = sq_b_q;
      assign root_b = '0;
      assign ry     = roll_y_q;
      assign rx     = roll_x_q;
      assign yy     = yaw_y_q;
      assign yx     = yaw_x_q;
    end else begin : g_next
      assign rem_a  = ra_q[k-1];
      assign root_a = ta_q[k-1];
      assign rem_b  = rb_q[k-1];
      assign root_b = tb_q[k-1];
      assign ry     = d_ry_q[k-1];
      assign rx     = d_rx_q[k-1];
      assign yy     = d_yy_q[k-1];
      assign yx     = d_yx_q[k-1];
    end

    assign trial_a = {1'b0, root_a} + {1'b0, Bit};
    assign trial_b = {1'b0, root_b} + {1'b0, Bit};

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_ry_q[k] <= ry;
        d_rx_q[k] <= rx;
        d_yy_q[k] <= yy;
        d_yx_q[k] <= yx;
        if ({1'b0, rem_a} >= trial_a) begin
          ra_q[k] <= rem_a - trial_a[AW-1:0];
          ta_q[k] <= (root_a >> 1) + Bit;
        end else begin
          ra_q[k] <= rem_a;
          ta_q[k] <= root_a >> 1;
        end
        if ({1'b0, rem_b} >= trial_b) begin
          rb_q[k] <= rem_b - trial_b[AW-1:0];
          tb_q[k] <= (root_b >> 1) + Bit;
        end else begin
          rb_q[k] <= rem_b;
          tb_q[k] <= root_b >> 1;
        end
      end
    end
  end

  // three cordic pipelines run side by side; roots are below 2^(AW/2), so positive
  qte_pkg::ang_t roll_acc, pitch_acc, yaw_acc;

  qte_cordic #(.NumStages(CORDIC_STAGES), .InW(AW)) u_roll (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (d_rx_q[NSQ-1]),
    .y_i    (d_ry_q[NSQ-1]),
    .angle_o(roll_acc)
  );

  qte_cordic #(.NumStages(CORDIC_STAGES), .InW(AW)) u_pitch (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    ($signed(tb_q[NSQ-1])),
    .y_i    ($signed(ta_q[NSQ-1])),
    .angle_o(pitch_acc)
  );

  qte_cordic #(.NumStages(CORDIC_STAGES), .InW(AW)) u_yaw (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (d_yx_q[NSQ-1]),
    .y_i    (d_yy_q[NSQ-1]),
    .angle_o(yaw_acc)
  );

  // output stage: pitch = 2*angle - pi/2, round half up to 13 fraction bits, saturate
  logic signed [29:0] pitch_full, pitch_r;
  qte_pkg::ang_t      roll_r, yaw_r;
  logic signed [29:0] pitch_lim;

  assign pitch_full = (30'(pitch_acc) <<< 1) - 30'(qte_pkg::AngHalfPi);
  assign pitch_r    = (pitch_full + 30'sd1024) >>> 11;
  assign roll_r     = (roll_acc + 28'sd1024) >>> 11;
  assign yaw_r      = (yaw_acc + 28'sd1024) >>> 11;
  assign pitch_lim  = 30'(qte_pkg::OutHalfPi);

  logic signed [15:0] roll_d, yaw_d;
  logic signed [14:0] pitch_d;

  always_comb begin
    if (roll_r > qte_pkg::OutPi) begin
      roll_d = 16'(qte_pkg::OutPi);
    end else if (roll_r < -qte_pkg::OutPi) begin
      roll_d = 16'(-qte_pkg::OutPi);
    end else begin
      roll_d = roll_r[15:0];
    end
    if (yaw_r > qte_pkg::OutPi) begin
      yaw_d = 16'(qte_pkg::OutPi);
    end else if (yaw_r < -qte_pkg::OutPi) begin
      yaw_d = 16'(-qte_pkg::OutPi);
    end else begin
      yaw_d = yaw_r[15:0];
    end
    if (pitch_r > pitch_lim) begin
      pitch_d = pitch_lim[14:0];
    end else if (pitch_r < -pitch_lim) begin
      pitch_d = 15'(-pitch_lim);
    end else begin
      pitch_d = pitch_r[14:0];
    end
  end

  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && pv_q[PD-1]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && pv_q[PD-1]) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

  // stall only when the last stage and the output register are both occupied
  `QTE_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, pv_q[PD-1] && out_valid_q)
  // an accepted word enters the first stage
  `QTE_ASSERT_NEXT(a_enter, clk_i, rst_ni, in_valid_i && in_ready_o, pv_q[0])
  // pitch stays within half pi
  `QTE_ASSERT_NOW(a_pitch_range, clk_i, rst_ni, out_valid_o, (pitch_angle_o <= 15'sd12868) && (pitch_angle_o >= -15'sd12868))

endmodule

// ===== hw/rtl/qte_cordic.sv =====
// pipelined vectoring cordic atan2, one register stage per iteration
// quadrant pre-rotation stage first; uses qte_pkg angle types and table
module qte_cordic #(
  parameter int NumStages = 16,
  parameter int InW       = 34
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [InW-1:0] x_i,
  input  logic signed [InW-1:0] y_i,
  output qte_pkg::ang_t         angle_o
);

  localparam int CW = InW + 2;

  logic signed [CW-1:0] x_q   [NumStages+1];
  logic signed [CW-1:0] y_q   [NumStages+1];
  qte_pkg::ang_t        acc_q [NumStages+1];
  logic                 zero_q[NumStages+1];

  logic signed [CW-1:0] xe, ye;
  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  // pre-rotation into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (xe[CW-1]) begin
        if (!ye[CW-1]) begin
          x_q[0]   <= ye;
          y_q[0]   <= -xe;
          acc_q[0] <= qte_pkg::AngHalfPi;
        end else begin
          x_q[0]   <= -ye;
          y_q[0]   <= xe;
          acc_q[0] <= -qte_pkg::AngHalfPi;
        end
      end else begin
        x_q[0]   <= xe;
        y_q[0]   <= ye;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i][CW-1]) begin
          x_q[i+1]   <= x_q[i] - dx;
          y_q[i+1]   <= y_q[i] + dy;
          acc_q[i+1] <= acc_q[i] - qte_pkg::atan_entry(i);
        end else begin
          x_q[i+1]   <= x_q[i] + dx;
          y_q[i+1]   <= y_q[i] - dy;
          acc_q[i+1] <= acc_q[i] + qte_pkg::atan_entry(i);
        end
      end
    end
  end

  assign angle_o = zero_q[NumStages] ? '0 : acc_q[NumStages];

endmodule

// ===== sim/tb_top.sv =====
// testbench for the quaternion to roll/pitch/yaw pipeline: random and directed words
// scored against a fixed-point cordic predictor; depends on qte_pkg and the rtl top
`timescale 1ns / 100ps

typedef struct {
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;
} euler_t;

class euler_scoreboard;
  euler_t pending[$];
  int     fails;

  // atan(2^-i), 24 fraction bits
  function automatic longint atan_step(int i);
    if (i < 8) return longint'(qte_pkg::AtanLow[i]);
    if (i <= qte_pkg::AngFrac) return longint'(1) << (qte_pkg::AngFrac - i);
    return 0;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint acc, t, dx, dy;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    // pre-rotate the left half plane by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        acc = longint'(qte_pkg::AngHalfPi);
      end else begin
        x = -y;
        y = t;
        acc = -longint'(qte_pkg::AngHalfPi);
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        acc = acc - atan_step(i);
      end else begin
        x = x + dx;
        y = y - dy;
        acc = acc + atan_step(i);
      end
    end
    return acc;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(root);
  endfunction

  function automatic longint round_clamp(longint acc, longint lim);
    longint r;
    r = (acc + 1024) >>> 11;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function void note(logic signed [15:0] qw, logic signed [15:0] qx,
                     logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, one, t, a, b, r, p, yw;
    euler_t e;
    w = longint'(qw);
    x = longint'(qx);
    y = longint'(qy);
    z = longint'(qz);
    one = longint'(1) << 28;
    r  = cordic_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y));
    yw = cordic_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
    t = w * y - x * z;
    a = one + 2 * t;
    b = one - 2 * t;
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    p = 2 * cordic_angle(root_floor(a), root_floor(b)) - longint'(qte_pkg::AngHalfPi);
    e.roll  = 16'(round_clamp(r, 25736));
    e.pitch = 15'(round_clamp(p, 12868));
    e.yaw   = 16'(round_clamp(yw, 25736));
    pending.push_back(e);
  endfunction

  function void check(logic signed [15:0] roll, logic signed [14:0] pitch,
                      logic signed [15:0] yaw);
    euler_t e;
    if (pending.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected word roll=%0d pitch=%0d yaw=%0d", roll, pitch, yaw);
      return;
    end
    e = pending.pop_front();
    if (e.roll !== roll || e.pitch !== pitch || e.yaw !== yaw) begin
      fails++;
      if (fails <= 10)
        $display("mismatch: exp roll=%0d pitch=%0d yaw=%0d got roll=%0d pitch=%0d yaw=%0d",
                 e.roll, e.pitch, e.yaw, roll, pitch, yaw);
    end
  endfunction
endclass

module tb_top;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] roll_angle_o, yaw_angle_o;
  logic signed [14:0] pitch_angle_o;

  euler_scoreboard sb = new();
  int words_in;          // accepted input words
  int send_idle_pct;     // sender idle chance, percent
  int recv_idle_pct;     // receiver stall chance, percent
  int hold_left;         // long receiver hold-off, in cycles
  int quiet_cycles;      // cycles with no handshake on either side

  localparam int WatchdogLimit = 5000;

  quaternion_to_euler_angles dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // monitors sample at the rising edge, before the dut updates
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sb.note(quat_w_i, quat_x_i, quat_y_i, quat_z_i);
      words_in++;
    end
    if (out_valid_o && out_ready_i) sb.check(roll_angle_o, pitch_angle_o, yaw_angle_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one word and wait until it is taken; inputs move at the falling edge
  task automatic send_word(int w, int x, int y, int z);
    int seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    quat_w_i = 16'(w);
    quat_x_i = 16'(x);
    quat_y_i = 16'(y);
    quat_z_i = 16'(z);
    in_valid_i = 1'b1;
    seen = words_in;
    while (words_in == seen) @(negedge clk_i);
  endtask

  // unit quaternion of random direction
  task automatic send_unit();
    real a, b, c, d, n;
    a = real'($urandom_range(2000)) - 1000.0;
    b = real'($urandom_range(2000)) - 1000.0;
    c = real'($urandom_range(2000)) - 1000.0;
    d = real'($urandom_range(2000)) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      send_word(16384, 0, 0, 0);
    end else begin
      send_word($rtoi(16384.0 * a / n), $rtoi(16384.0 * b / n),
                $rtoi(16384.0 * c / n), $rtoi(16384.0 * d / n));
    end
  endtask

  task automatic send_random();
    int pick;
    int s;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_unit();
    end else if (pick < 65) begin
      // close to gimbal lock: w and y nearly equal or opposite
      s = $urandom_range(1) ? 1 : -1;
      send_word(11585 + $urandom_range(40) - 20, $urandom_range(60) - 30,
                s * (11585 + $urandom_range(40) - 20), $urandom_range(60) - 30);
    end else if (pick < 85) begin
      send_word($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
    end else begin
      // raw patterns, beyond unit range
      send_word(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    end
  endtask

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 70;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed words
    send_word(16384, 0, 0, 0);               // identity
    send_word(-16384, 0, 0, 0);
    send_word(0, 0, 0, 0);                   // all-zero quaternion
    send_word(0, 16384, 0, 0);               // roll on the negative real axis
    send_word(0, 0, 0, 16384);               // yaw on the negative real axis
    send_word(0, 0, 16384, 0);
    send_word(11585, 11585, 0, 0);           // quarter turns about each axis
    send_word(11585, 0, 11585, 0);           // gimbal lock, pitch up
    send_word(11585, 0, -11585, 0);          // gimbal lock, pitch down
    send_word(11585, 0, 0, 11585);
    send_word(16384, 0, 16384, 0);           // negative sqrt argument clamped
    send_word(16384, 0, -16384, 0);
    send_word(0, 16384, 0, 16384);
    send_word(32767, 32767, 32767, 32767);   // field extremes
    send_word(-32768, -32768, -32768, -32768);
    send_word(32767, -32768, 32767, -32768);
    send_word(-32768, 32767, -32768, 32767);
    send_word(0, 0, 32767, 0);
    send_word(16384, 16384, 16384, 16384);
    send_word(-16384, 16384, -16384, 16384);
    send_word(8192, 8192, 8192, 8192);

    for (int i = 0; i < 600; i++) send_random();
    send_idle_pct = 70;
    recv_idle_pct = 33;
    for (int i = 0; i < 600; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold-off while words keep coming, so the pipe backs up
    hold_left = 300;
    for (int i = 0; i < 700; i++) send_random();
    in_valid_i = 1'b0;

    while (sb.pending.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
sim/tb_top.sv
